[rtl/time_window_mean_aggregator_unit_macros.svh]
// ----------------------------------------------------------------------------
// Time window mean aggregator: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TIME_WINDOW_MEAN_AGGREGATOR_UNIT_MACROS_SVH
`define TIME_WINDOW_MEAN_AGGREGATOR_UNIT_MACROS_SVH

// Same-cycle implication
`define TWMA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TWMA_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/twma_pkg.sv]
// ----------------------------------------------------------------------------
// twma_pkg
// Field widths, register map and shared types of the time window mean
// aggregator.
// ----------------------------------------------------------------------------
package twma_pkg;

    // Field widths
    localparam int TIME_W     = 63;
    localparam int VALUE_W    = 32;
    localparam int INTERVAL_W = 48;

    // Configuration port
    localparam int PDATA_W = 64;
    localparam int PADDR_W = 4;

    // Register indexes (taken from paddr[3], registers on 8-byte steps)
    localparam logic REG_CLOSE_SPAN = 1'b0;

    localparam logic [INTERVAL_W-1:0] CLOSE_SPAN_RESET = 48'd1000000000;

    // Divider sequencer states
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    // Queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

[rtl/twma_sample_if.sv]
// ----------------------------------------------------------------------------
// twma_sample_if
// Valid/ready channel carrying one timestamped sample.
// ----------------------------------------------------------------------------
interface twma_sample_if;

    logic                                 valid;
    logic                                 ready;
    logic [twma_pkg::TIME_W-1:0]          sample_time;
    logic signed [twma_pkg::VALUE_W-1:0]  sample_value;

    modport source (output valid, output sample_time, output sample_value, input ready);
    modport sink   (input valid, input sample_time, input sample_value, output ready);

endinterface

[rtl/twma_result_if.sv]
// ----------------------------------------------------------------------------
// twma_result_if
// Valid/ready channel carrying one closed-window result.
// ----------------------------------------------------------------------------
interface twma_result_if;

    logic                                 valid;
    logic                                 ready;
    logic [twma_pkg::TIME_W-1:0]          out_time;
    logic signed [twma_pkg::VALUE_W-1:0]  out_mean;

    modport source (output valid, output out_time, output out_mean, input ready);
    modport sink   (input valid, input out_time, input out_mean, output ready);

endinterface

[rtl/twma_front.sv]
// ----------------------------------------------------------------------------
// twma_front
// Accepts samples, decides whether each one closes the current window and
// keeps the window state. A closing sample posts a divide job to the queue.
// ----------------------------------------------------------------------------
module twma_front #(
    parameter int COUNT_BITS = 16,
    parameter int SUM_W      = 48,
    parameter int JOB_W      = 127
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [twma_pkg::INTERVAL_W-1:0]     close_span,
    twma_sample_if.sink                         samples,
    input  twma_pkg::queue_stat_t               q_stat,
    output logic                                push,
    output logic [JOB_W-1:0]                    push_data
);

    localparam int TW = twma_pkg::TIME_W;
    localparam int VW = twma_pkg::VALUE_W;
    localparam int IW = twma_pkg::INTERVAL_W;

    logic [TW-1:0]          start_reg, start_next;
    logic [TW-1:0]          last_reg, last_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;

    logic                   accept;
    logic                   win_empty;
    logic                   cnt_full;
    logic [TW:0]            span;
    logic                   late;
    logic                   close;
    logic [SUM_W-1:0]       value_ext;

    // Handshake: hold off only while the job queue is full
    assign samples.ready = !q_stat.full;
    assign accept        = samples.valid && samples.ready;

    // Classification; a negative span is never late, so it closes the window only on a full count
    assign win_empty = (count_reg == '0);
    assign cnt_full  = &count_reg;
    assign span      = {1'b0, samples.sample_time} - {1'b0, start_reg};
    assign late      = !span[TW]
                       && (span[TW-1:0] > {{(TW-IW){1'b0}}, close_span});
    assign close     = !win_empty && (late || cnt_full);

    assign value_ext = {{(SUM_W-VW){samples.sample_value[VW-1]}}, samples.sample_value};

    // Divide job: last time, sum and count of the window being closed
    assign push      = accept && close;
    assign push_data = {last_reg, sum_reg, count_reg};

    // Window state update
    always_comb
    begin
        start_next = start_reg;
        last_next  = last_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept) begin
            last_next = samples.sample_time;
            if (win_empty || close) begin
                start_next = samples.sample_time;
                sum_next   = value_ext;
                count_next = COUNT_BITS'(1);
            end else begin
                sum_next   = sum_reg + value_ext;
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_reg <= '0;
            last_reg  <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end else begin
            start_reg <= start_next;
            last_reg  <= last_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/twma_queue.sv]
// ----------------------------------------------------------------------------
// twma_queue
// Short FIFO of divide jobs between the front and the divider.
// ----------------------------------------------------------------------------
module twma_queue #(
    parameter int DATA_W = 127,
    parameter int DEPTH  = 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [DATA_W-1:0]       push_data,
    input  logic                    pop,
    output logic [DATA_W-1:0]       pop_data,
    output twma_pkg::queue_stat_t   q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0]  mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;

    assign q_stat.full  = (fill_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (fill_reg == '0);
    assign pop_data     = mem[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/twma_divider.sv]
// ----------------------------------------------------------------------------
// twma_divider
// Back part: takes a divide job, runs a restoring division of the sum
// magnitude by the count one quotient bit per cycle and holds the result
// until it is taken.
// ----------------------------------------------------------------------------
module twma_divider #(
    parameter int COUNT_BITS = 16,
    parameter int SUM_W      = 48,
    parameter int JOB_W      = 127
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  twma_pkg::queue_stat_t   q_stat,
    input  logic [JOB_W-1:0]        job,
    output logic                    pop,
    twma_result_if.source           results
);

    localparam int TW     = twma_pkg::TIME_W;
    localparam int VW     = twma_pkg::VALUE_W;
    localparam int STEP_W = $clog2(SUM_W + 1);

    twma_pkg::div_state_t   state_reg, state_next;

    logic [TW-1:0]          time_reg;
    logic [SUM_W-1:0]       dvd_reg;
    logic [COUNT_BITS-1:0]  rem_reg;
    logic [COUNT_BITS-1:0]  dvs_reg;
    logic                   neg_reg;
    logic [STEP_W-1:0]      step_reg;

    logic [TW-1:0]          job_time;
    logic [SUM_W-1:0]       job_sum;
    logic [COUNT_BITS-1:0]  job_count;
    logic [SUM_W-1:0]       job_mag;

    logic [COUNT_BITS:0]    rem_shift;
    logic [COUNT_BITS+1:0]  trial;
    logic                   q_bit;
    logic                   load;
    logic                   run;
    logic                   last_step;
    logic [VW-1:0]          quot_lo;

    // Job unpacking and sum magnitude
    assign {job_time, job_sum, job_count} = job;
    assign job_mag = job_sum[SUM_W-1] ? (~job_sum + SUM_W'(1)) : job_sum;

    // One restoring step
    assign rem_shift = {rem_reg, dvd_reg[SUM_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b0, dvs_reg};
    assign q_bit     = !trial[COUNT_BITS+1];
    assign last_step = (step_reg == STEP_W'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            twma_pkg::DIV_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = twma_pkg::DIV_RUN;
                end
            end
            twma_pkg::DIV_RUN: begin
                if (last_step) begin
                    state_next = twma_pkg::DIV_DONE;
                end
            end
            twma_pkg::DIV_DONE: begin
                if (results.ready) begin
                    state_next = twma_pkg::DIV_IDLE;
                end
            end
            default: begin
                state_next = twma_pkg::DIV_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        load          = 1'b0;
        run           = 1'b0;
        results.valid = 1'b0;
        case (state_reg)
            twma_pkg::DIV_IDLE: load          = !q_stat.empty;
            twma_pkg::DIV_RUN:  run           = 1'b1;
            twma_pkg::DIV_DONE: results.valid = 1'b1;
            default: begin
                load = 1'b0;
            end
        endcase
    end

    assign pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= twma_pkg::DIV_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                step_reg <= STEP_W'(SUM_W);
            end else if (run) begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    // Division datapath; quotient bits shift in as dividend bits shift out
    always_ff @(posedge clk)
    begin
        if (load) begin
            time_reg <= job_time;
            dvd_reg  <= job_mag;
            rem_reg  <= '0;
            dvs_reg  <= job_count;
            neg_reg  <= job_sum[SUM_W-1];
        end else if (run) begin
            dvd_reg <= {dvd_reg[SUM_W-2:0], q_bit};
            rem_reg <= q_bit ? trial[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
        end
    end

    // Result: sign restored, truncation toward zero falls out of the magnitude
    assign quot_lo          = dvd_reg[VW-1:0];
    assign results.out_time = time_reg;
    assign results.out_mean = neg_reg ? (VW'(0) - quot_lo) : quot_lo;

endmodule

[rtl/time_window_mean_aggregator_unit.sv]
// Flow: a closing sample's job is written to the queue; the divider loads it when idle,
// runs the bit-serial restoring division and holds the result until it is transferred.
// Throughput: one sample per cycle while the job queue is not full; the divider takes a
// new job only after the last result is transferred.
// Reset: the window span limit returns to 1000000000 ns, the window is empty, the queue empties.
// ----------------------------------------------------------------------------
// time_window_mean_aggregator_unit
// Boxcar average decimator over time windows of timestamped Q16.16 samples,
// with an APB-style register port for the window span limit.
// ----------------------------------------------------------------------------
`include "time_window_mean_aggregator_unit_macros.svh"

module time_window_mean_aggregator_unit #(
    parameter int COUNT_BITS  = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    twma_sample_if.sink                         samples,
    twma_result_if.source                       results,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [twma_pkg::PADDR_W-1:0]        paddr,
    input  logic [twma_pkg::PDATA_W-1:0]        pwdata,
    output logic [twma_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam int SUM_W = twma_pkg::VALUE_W + COUNT_BITS;
    localparam int JOB_W = twma_pkg::TIME_W + SUM_W + COUNT_BITS;
    localparam int IW    = twma_pkg::INTERVAL_W;

    logic [IW-1:0]          close_span_reg;
    logic                   cfg_wr;
    logic                   push;
    logic                   pop;
    logic [JOB_W-1:0]       push_data;
    logic [JOB_W-1:0]       pop_data;
    twma_pkg::queue_stat_t  q_stat;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[3] == twma_pkg::REG_CLOSE_SPAN);
    assign prdata = (paddr[3] == twma_pkg::REG_CLOSE_SPAN)
                    ? {{(twma_pkg::PDATA_W-IW){1'b0}}, close_span_reg}
                    : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            close_span_reg <= twma_pkg::CLOSE_SPAN_RESET;
        end else if (cfg_wr) begin
            close_span_reg <= pwdata[IW-1:0];
        end
    end

    // Front: classification and window state
    twma_front #(
        .COUNT_BITS (COUNT_BITS),
        .SUM_W      (SUM_W),
        .JOB_W      (JOB_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .close_span   (close_span_reg),
        .samples      (samples),
        .q_stat       (q_stat),
        .push         (push),
        .push_data    (push_data)
    );

    // Job queue
    twma_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    // Back: mean division and result register
    twma_divider #(
        .COUNT_BITS (COUNT_BITS),
        .SUM_W      (SUM_W),
        .JOB_W      (JOB_W)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .job     (pop_data),
        .pop     (pop),
        .results (results)
    );

    // Checks
    `TWMA_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !q_stat.full, "job pushed into full queue")
    `TWMA_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, !q_stat.empty, "job popped from empty queue")
    `TWMA_ASSERT_NXT(a_busy_after_pop, clk, rst_n, pop, !results.valid, "result shown while dividing")

endmodule
